/* rtl/matrix_column_transform_4x4_unit_macros.svh */
// ---------------------------------------------------------------------------
// matrix_column_transform_4x4_unit_macros.svh
// Assertion macros shared by the matrix column transform RTL
// ---------------------------------------------------------------------------
`ifndef MATRIX_COLUMN_TRANSFORM_4X4_UNIT_MACROS_SVH
`define MATRIX_COLUMN_TRANSFORM_4X4_UNIT_MACROS_SVH

// implication checked every clock outside reset
`define MCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mct implication check failed");

// next-cycle implication checked every clock outside reset
`define MCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mct next-cycle check failed");

// next-cycle implication that also holds through reset
`define MCT_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mct reset check failed");

`endif

/* rtl/mct4_pkg.sv */
// ---------------------------------------------------------------------------
// mct4_pkg
// Types and constants of the 4x4 fixed-point matrix column transform
// ---------------------------------------------------------------------------
package mct4_pkg;

  // matrix geometry and number format
  localparam int Dim      = 4;
  localparam int ElemW    = 32;
  localparam int FracBits = 16;
  localparam int NumRegs  = 8;
  localparam int RegW     = 64;
  localparam int IndexW   = 4;
  localparam int ColW     = 2;

  // intermediate widths: exact product, pair sum, total sum, shifted total
  localparam int ProdW  = 2 * ElemW;
  localparam int PairW  = ProdW + 1;
  localparam int TotalW = ProdW + 2;
  localparam int ShiftW = TotalW - FracBits;

  typedef logic signed [ElemW-1:0]  elem_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [PairW-1:0]  pair_t;
  typedef logic signed [ShiftW-1:0] shifted_t;
  typedef logic        [RegW-1:0]   areg_t;
  typedef logic        [ColW-1:0]   col_t;

  // saturation limits
  localparam elem_t ElemMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam elem_t ElemMin = {1'b1, {(ElemW-1){1'b0}}};

  // reset value of A: identity matrix
  localparam areg_t ARegReset [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

endpackage

/* rtl/matrix_column_transform_4x4_unit.sv */
// ---------------------------------------------------------------------------
// matrix_column_transform_4x4_unit
// Multiplies a stored 4x4 Q16.16 matrix A by one column of B per transaction
// ---------------------------------------------------------------------------
// Accepts one B column per clock and returns one saturated Q16.16 product
// column per clock, in order, while the output is not stalled. The pipeline
// has four register stages: sixteen parallel 32x32 multipliers, pair adds,
// the final add with the floor shift by 16, and saturation into the output
// register. Throughput is set by the multiplier stage, which takes a whole
// column each cycle unless a stall holds it; a stall at the output backs up
// stage by stage, and in_ready drops only once every stage holds a
// transaction. The user must write A through the cfg port only while no
// transaction is in flight; the block itself does not enforce this. Indexes
// above seven are ignored.
`include "matrix_column_transform_4x4_unit_macros.svh"

module matrix_column_transform_4x4_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [mct4_pkg::IndexW-1:0]  cfg_index,
  input  logic [mct4_pkg::RegW-1:0]    cfg_data,
  // input column
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mct4_pkg::ColW-1:0]    in_column_number,
  input  logic signed [mct4_pkg::ElemW-1:0] in_b_elem0,
  input  logic signed [mct4_pkg::ElemW-1:0] in_b_elem1,
  input  logic signed [mct4_pkg::ElemW-1:0] in_b_elem2,
  input  logic signed [mct4_pkg::ElemW-1:0] in_b_elem3,
  // result column
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mct4_pkg::ColW-1:0]    out_column,
  output logic signed [mct4_pkg::ElemW-1:0] out_prod_row0,
  output logic signed [mct4_pkg::ElemW-1:0] out_prod_row1,
  output logic signed [mct4_pkg::ElemW-1:0] out_prod_row2,
  output logic signed [mct4_pkg::ElemW-1:0] out_prod_row3,
  output logic                         out_clipped
);

  localparam int Dim      = mct4_pkg::Dim;
  localparam int ElemW    = mct4_pkg::ElemW;
  localparam int FracBits = mct4_pkg::FracBits;
  localparam int NumRegs  = mct4_pkg::NumRegs;
  localparam int ShiftW   = mct4_pkg::ShiftW;
  localparam int TotalW   = mct4_pkg::TotalW;

  // matrix A registers
  mct4_pkg::areg_t a_r [NumRegs];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NumRegs; k++) begin
        a_r[k] <= mct4_pkg::ARegReset[k];
      end
    end else if (cfg_we && !cfg_index[mct4_pkg::IndexW-1]) begin
      a_r[cfg_index[mct4_pkg::IndexW-2:0]] <= cfg_data;
    end
  end

  // element view of A: a_elem[col][row]
  mct4_pkg::elem_t a_elem [Dim][Dim];
  mct4_pkg::elem_t b_in   [Dim];

  always_comb begin
    for (int c = 0; c < Dim; c++) begin
      for (int r = 0; r < Dim; r++) begin
        a_elem[c][r] = a_r[2 * c + r / 2][(r % 2) * ElemW +: ElemW];
      end
    end
    b_in[0] = in_b_elem0;
    b_in[1] = in_b_elem1;
    b_in[2] = in_b_elem2;
    b_in[3] = in_b_elem3;
  end

  // stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: sixteen exact products
  mct4_pkg::prod_t prod_r [Dim][Dim];
  mct4_pkg::col_t  col1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      col1_r <= in_column_number;
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          prod_r[r][c] <= a_elem[c][r] * b_in[c];
        end
      end
    end
  end

  // stage 2: pair sums per row
  mct4_pkg::pair_t pair_r [Dim][2];
  mct4_pkg::col_t  col2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      col2_r <= col1_r;
      for (int r = 0; r < Dim; r++) begin
        pair_r[r][0] <= {prod_r[r][0][mct4_pkg::ProdW-1], prod_r[r][0]}
                      + {prod_r[r][1][mct4_pkg::ProdW-1], prod_r[r][1]};
        pair_r[r][1] <= {prod_r[r][2][mct4_pkg::ProdW-1], prod_r[r][2]}
                      + {prod_r[r][3][mct4_pkg::ProdW-1], prod_r[r][3]};
      end
    end
  end

  // stage 3: full sum, floor shift by the fraction bits
  logic [TotalW-1:0]    total [Dim];
  mct4_pkg::shifted_t   shf_r [Dim];
  mct4_pkg::col_t       col3_r;

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      total[r] = {pair_r[r][0][mct4_pkg::PairW-1], pair_r[r][0]}
               + {pair_r[r][1][mct4_pkg::PairW-1], pair_r[r][1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      col3_r <= col2_r;
      for (int r = 0; r < Dim; r++) begin
        shf_r[r] <= total[r][TotalW-1:FracBits];
      end
    end
  end

  // stage 4: saturate into the output register
  logic                  ovf [Dim];
  mct4_pkg::elem_t       sat [Dim];
  logic                  clip_nxt;
  mct4_pkg::elem_t       row_r [Dim];
  logic                  clipped_r;
  mct4_pkg::col_t        col4_r;

  always_comb begin
    clip_nxt = 1'b0;
    for (int r = 0; r < Dim; r++) begin
      ovf[r] = !((&shf_r[r][ShiftW-1:ElemW-1]) || !(|shf_r[r][ShiftW-1:ElemW-1]));
      if (!ovf[r]) begin
        sat[r] = shf_r[r][ElemW-1:0];
      end else if (shf_r[r][ShiftW-1]) begin
        sat[r] = mct4_pkg::ElemMin;
      end else begin
        sat[r] = mct4_pkg::ElemMax;
      end
      clip_nxt = clip_nxt | ovf[r];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      col4_r    <= col3_r;
      clipped_r <= clip_nxt;
      for (int r = 0; r < Dim; r++) begin
        row_r[r] <= sat[r];
      end
    end
  end

  // result ports
  assign out_valid     = v4_r;
  assign out_column    = col4_r;
  assign out_prod_row0 = row_r[0];
  assign out_prod_row1 = row_r[1];
  assign out_prod_row2 = row_r[2];
  assign out_prod_row3 = row_r[3];
  assign out_clipped   = clipped_r;

  // assertions
  `MCT_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid && in_ready)
  `MCT_ASSERT_IMP(a_full_when_blocked, !in_ready, v1_r && v2_r && v3_r && v4_r)
  `MCT_ASSERT_NEXT(a_stage3_holds, v3_r && !en4, v3_r && $stable(shf_r[0]))
  `MCT_ASSERT_IMP(a_clip_at_limit, out_valid && out_clipped,
    out_prod_row0 == mct4_pkg::ElemMax || out_prod_row0 == mct4_pkg::ElemMin ||
    out_prod_row1 == mct4_pkg::ElemMax || out_prod_row1 == mct4_pkg::ElemMin ||
    out_prod_row2 == mct4_pkg::ElemMax || out_prod_row2 == mct4_pkg::ElemMin ||
    out_prod_row3 == mct4_pkg::ElemMax || out_prod_row3 == mct4_pkg::ElemMin)

endmodule
